// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and byte tables of the stored-block PNG encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned DEF_MAX_WIDTH   = 8192;
  localparam int unsigned DEF_MAX_HEIGHT  = 8192;
  localparam int unsigned DEF_BLOCK_LIMIT = 65535;

  localparam int unsigned DIM_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SIG,
    S_IHDR_LEN,
    S_IHDR_TYPE,
    S_IHDR_W,
    S_IHDR_H,
    S_IHDR_TAIL,
    S_IHDR_CRC,
    S_WAIT_LEN,
    S_IDAT_LEN,
    S_IDAT_TYPE,
    S_ZHDR,
    S_RAW,
    S_BLK,
    S_ADLER,
    S_IDAT_CRC,
    S_IEND_LEN,
    S_IEND_TYPE,
    S_IEND_CRC
  } state_e;

  typedef enum logic [3:0] {
    SEL_SIG,
    SEL_LEN13,
    SEL_TYPE_IHDR,
    SEL_WIDTH,
    SEL_HEIGHT,
    SEL_IHDR_TAIL,
    SEL_CRC,
    SEL_IDAT_LEN,
    SEL_TYPE_IDAT,
    SEL_ZHDR,
    SEL_BLK,
    SEL_FILTER,
    SEL_SAMPLE,
    SEL_ADLER,
    SEL_ZERO,
    SEL_TYPE_IEND
  } sel_e;

  typedef enum logic [1:0] {
    LEN_IDLE,
    LEN_LOAD,
    LEN_DIV,
    LEN_SUM
  } len_st_e;

  typedef struct packed {
    logic       emit;
    sel_e       sel;
    logic [3:0] idx;
    logic       crc_on;
    logic       crc_init;
    logic       raw_step;
    logic       col_step;
    logic       blk_load;
    logic       latch;
    logic       calc_start;
    logic       file_init;
    logic       restart;
    logic       run_end;
    logic       file_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic blk_zero;
    logic raw_last;
    logic col_zero;
    logic calc_done;
  } stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd137;
      3'd1:    r = 8'd80;
      3'd2:    r = 8'd78;
      3'd3:    r = 8'd71;
      3'd4:    r = 8'd13;
      3'd5:    r = 8'd10;
      3'd6:    r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/png_stored_rgb_encoder.sv =====
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder
// RGB bytes in, PNG file bytes out (IHDR, one IDAT of stored deflate blocks,
// IEND) on a registered output, one sample taken at a time.
// ----------------------------------------------------------------------------
// Sequence: an interior sample is accepted, then emitted; a row start adds
//   the filter byte, a block start its header.
// First sample of a file: 43 header bytes, with a wait for the IDAT length
//   after IHDR; the size unit has it ready well before the sequencer waits.
// Last sample adds 20 trailer bytes. Output stalls hold the sequencer.
// Reset: async active low; image size back to 1x1, next beat opens a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module png_stored_rgb_encoder import pse_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned BLOCK_LIMIT = DEF_BLOCK_LIMIT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes: index 0 width, index 1 height
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  // sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           sample_byte_i,
  // file byte channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [7:0]           out_byte_o,
  output logic                      run_end_o,
  output logic                      file_end_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_restart;

  // a write to a known register restarts the file
  assign cfg_restart = cfg_we_i &&
                       (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);

  // sequencer: one section byte per step, holds while the output is full
  pse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_restart_i(cfg_restart),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // datapath: checksums, counters, size unit and the output register
  pse_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BLOCK_LIMIT(BLOCK_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_byte_i(sample_byte_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .file_end_o   (file_end_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pse_len.sv =====
// ----------------------------------------------------------------------------
// pse_len
// Raw stream size and IDAT length: one multiply for the raw size, then the
// block count by multiplying with the reciprocal of the stored block size.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_len import pse_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned BLOCK_LIMIT = DEF_BLOCK_LIMIT,
  parameter int unsigned RAW_W       = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  output logic      [RAW_W-1:0] raw_o,
  output logic      [31:0]      idat_len_o,
  output logic                  done_o
);

  localparam int unsigned BLOCK_EFF = (BLOCK_LIMIT < 2) ? 2 : BLOCK_LIMIT;
  localparam int unsigned CMP_W     = (RAW_W > 17) ? RAW_W : 17;
  localparam int unsigned DIV_W     = CMP_W + 1;
  // rounded-up reciprocal, exact for every dividend below 2**DIV_W
  localparam int unsigned SHIFT     = DIV_W + $clog2(BLOCK_EFF);
  localparam int unsigned REC_W     = DIV_W + 1;
  localparam int unsigned MUL_W     = DIV_W + REC_W;
  localparam int unsigned QUO_W     = MUL_W - SHIFT;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(BLOCK_EFF) - 64'd1) / 64'(BLOCK_EFF);
  localparam logic [REC_W-1:0] RECIP_C = REC_W'(RECIP);

  len_st_e          st_q;
  logic [RAW_W-1:0] raw_q;
  logic [DIV_W-1:0] dvd_q;
  logic [QUO_W-1:0] quo_q;
  logic [31:0]      idat_q;
  logic             done_q;

  logic [15:0]      factor;
  logic [29:0]      prod;
  logic [MUL_W-1:0] mul;

  assign factor = {1'b0, width_i, 1'b0} + {2'b00, width_i} + 16'd1;
  assign prod   = 30'(height_i) * 30'(factor);
  assign mul    = MUL_W'(dvd_q) * MUL_W'(RECIP_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LEN_IDLE;
      done_q <= 1'b0;
    end else begin
      case (st_q)
        LEN_IDLE: begin
          if (start_i) begin
            done_q <= 1'b0;
            st_q   <= LEN_LOAD;
          end
        end
        LEN_LOAD: st_q <= LEN_DIV;
        LEN_DIV:  st_q <= LEN_SUM;
        LEN_SUM: begin
          done_q <= 1'b1;
          st_q   <= LEN_IDLE;
        end
        default: st_q <= LEN_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      LEN_IDLE: begin
        if (start_i) begin
          raw_q <= RAW_W'(prod);
        end
      end
      LEN_LOAD: begin
        // bias the dividend so the quotient rounds up
        dvd_q <= DIV_W'(raw_q) + DIV_W'(BLOCK_EFF - 1);
      end
      LEN_DIV: begin
        quo_q <= mul[SHIFT +: QUO_W];
      end
      LEN_SUM: begin
        idat_q <= 32'd6 + 32'(raw_q) + (32'(quo_q) << 2) + 32'(quo_q);
      end
      default: ;
    endcase
  end

  assign raw_o      = raw_q;
  assign idat_len_o = idat_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== rtl/pse_dp.sv =====
// ----------------------------------------------------------------------------
// pse_dp
// Datapath: image registers, byte select, CRC-32, Adler-32, stream counters
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_dp import pse_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned BLOCK_LIMIT = DEF_BLOCK_LIMIT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  input  wire logic [7:0]           sample_byte_i,
  input  wire logic                 out_ready_i,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  output logic                      out_valid_o,
  output logic      [7:0]           out_byte_o,
  output logic                      run_end_o,
  output logic                      file_end_o
);

  localparam int unsigned BLOCK_EFF = (BLOCK_LIMIT < 2) ? 2 : BLOCK_LIMIT;
  localparam int unsigned RAW_W     = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1);
  localparam int unsigned CMP_W     = (RAW_W > 17) ? RAW_W : 17;
  localparam int unsigned TW        = $clog2(3 * MAX_WIDTH + 1);

  logic [DIM_W-1:0] width_q, height_q;
  logic [31:0]      crc_q;
  logic [15:0]      adl_a_q, adl_b_q;
  logic [TW-1:0]    col_q;
  logic [15:0]      blk_q;
  logic [RAW_W-1:0] raw_left_q;
  logic [7:0]       sample_q;
  logic             out_valid_q, run_end_q, file_end_q;
  logic [7:0]       out_byte_q;

  logic [RAW_W-1:0] raw_total;
  logic [31:0]      idat_len;
  logic             calc_done;
  logic             cfg_hit;
  logic [DIM_W-1:0] cfg_clamped;
  logic [CMP_W-1:0] raw_ext, eff_c;
  logic [15:0]      blk_size;
  logic             bfinal;
  logic [7:0]       byte_v;
  logic [16:0]      a_sum, b_sum;
  logic [15:0]      a_n, b_n;
  logic [TW-1:0]    row_len, col_n;

  pse_len #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BLOCK_LIMIT(BLOCK_LIMIT),
    .RAW_W      (RAW_W)
  ) u_len (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.calc_start),
    .width_i   (width_q),
    .height_i  (height_q),
    .raw_o     (raw_total),
    .idat_len_o(idat_len),
    .done_o    (calc_done)
  );

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);

  always_comb begin
    cfg_clamped = (cfg_data_i == '0) ? DIM_W'(1) : cfg_data_i;
    if (cfg_idx_i == REG_IMAGE_WIDTH) begin
      if (15'(cfg_clamped) > 15'(MAX_WIDTH)) cfg_clamped = DIM_W'(MAX_WIDTH);
    end else begin
      if (15'(cfg_clamped) > 15'(MAX_HEIGHT)) cfg_clamped = DIM_W'(MAX_HEIGHT);
    end
  end

  assign raw_ext  = CMP_W'(raw_left_q);
  assign eff_c    = CMP_W'(BLOCK_EFF);
  assign blk_size = (raw_ext < eff_c) ? raw_ext[15:0] : eff_c[15:0];
  assign bfinal   = !(raw_ext > eff_c);

  always_comb begin
    case (cmd_i.sel)
      SEL_SIG:       byte_v = sig_byte(cmd_i.idx[2:0]);
      SEL_LEN13:     byte_v = word_byte(32'd13, cmd_i.idx[1:0]);
      SEL_TYPE_IHDR: byte_v = word_byte(32'h49484452, cmd_i.idx[1:0]);
      SEL_WIDTH:     byte_v = word_byte(32'(width_q), cmd_i.idx[1:0]);
      SEL_HEIGHT:    byte_v = word_byte(32'(height_q), cmd_i.idx[1:0]);
      SEL_IHDR_TAIL: byte_v = (cmd_i.idx == 4'd0) ? 8'd8 : (cmd_i.idx == 4'd1) ? 8'd2 : 8'd0;
      SEL_CRC:       byte_v = word_byte(~crc_q, cmd_i.idx[1:0]);
      SEL_IDAT_LEN:  byte_v = word_byte(idat_len, cmd_i.idx[1:0]);
      SEL_TYPE_IDAT: byte_v = word_byte(32'h49444154, cmd_i.idx[1:0]);
      SEL_ZHDR:      byte_v = (cmd_i.idx == 4'd0) ? 8'h78 : 8'h01;
      SEL_BLK: begin
        case (cmd_i.idx)
          4'd0:    byte_v = {7'd0, bfinal};
          4'd1:    byte_v = blk_size[7:0];
          4'd2:    byte_v = blk_size[15:8];
          4'd3:    byte_v = ~blk_size[7:0];
          default: byte_v = ~blk_size[15:8];
        endcase
      end
      SEL_FILTER:    byte_v = 8'd0;
      SEL_SAMPLE:    byte_v = sample_q;
      SEL_ADLER:     byte_v = word_byte({adl_b_q, adl_a_q}, cmd_i.idx[1:0]);
      SEL_ZERO:      byte_v = 8'd0;
      SEL_TYPE_IEND: byte_v = word_byte(32'h49454E44, cmd_i.idx[1:0]);
      default:       byte_v = 8'd0;
    endcase
  end

  // Adler-32 step, both sums kept reduced
  always_comb begin
    a_sum = {1'b0, adl_a_q} + {9'd0, byte_v};
    a_n   = (a_sum >= ADLER_MOD) ? 16'(a_sum - ADLER_MOD) : a_sum[15:0];
    b_sum = {1'b0, adl_b_q} + {1'b0, a_n};
    b_n   = (b_sum >= ADLER_MOD) ? 16'(b_sum - ADLER_MOD) : b_sum[15:0];
  end

  assign row_len = TW'({width_q, 1'b0}) + TW'(width_q);
  assign col_n   = col_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DIM_W'(1);
      height_q   <= DIM_W'(1);
      crc_q      <= '1;
      adl_a_q    <= 16'd1;
      adl_b_q    <= '0;
      col_q      <= '0;
      blk_q      <= '0;
      raw_left_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_WIDTH)  width_q  <= cfg_clamped;
      if (cfg_we_i && cfg_idx_i == REG_IMAGE_HEIGHT) height_q <= cfg_clamped;
      if (cfg_hit || cmd_i.restart) begin
        crc_q      <= '1;
        adl_a_q    <= 16'd1;
        adl_b_q    <= '0;
        col_q      <= '0;
        blk_q      <= '0;
        raw_left_q <= '0;
      end else if (cmd_i.file_init) begin
        adl_a_q    <= 16'd1;
        adl_b_q    <= '0;
        col_q      <= '0;
        blk_q      <= '0;
        raw_left_q <= raw_total;
      end else begin
        if (cmd_i.emit && cmd_i.crc_on) begin
          crc_q <= crc_byte(cmd_i.crc_init ? 32'hFFFFFFFF : crc_q, byte_v);
        end
        if (cmd_i.blk_load) blk_q <= blk_size;
        if (cmd_i.raw_step) begin
          adl_a_q    <= a_n;
          adl_b_q    <= b_n;
          blk_q      <= blk_q - 1'b1;
          raw_left_q <= raw_left_q - 1'b1;
        end
        if (cmd_i.col_step) col_q <= (col_n >= row_len) ? '0 : col_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) sample_q <= sample_byte_i;
  end

  // output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= byte_v;
      run_end_q  <= cmd_i.run_end;
      file_end_q <= cmd_i.file_end;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.blk_zero  = (blk_q == '0);
  assign stat_o.raw_last  = (raw_left_q == RAW_W'(1));
  assign stat_o.col_zero  = (col_q == '0);
  assign stat_o.calc_done = calc_done;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;
  assign file_end_o  = file_end_q;

endmodule

`default_nettype wire

// ===== rtl/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: walks the file sections one byte per step and issues datapath
// commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ctrl import pse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_restart_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       filt_q, filt_d;
  logic       phase_q, phase_d;
  logic [3:0] last;

  function automatic logic [3:0] last_idx(input state_e s);
    logic [3:0] r;
    case (s)
      S_SIG:               r = 4'd7;
      S_IHDR_TAIL, S_BLK:  r = 4'd4;
      S_ZHDR:              r = 4'd1;
      default:             r = 4'd3;
    endcase
    return r;
  endfunction

  function automatic state_e succ(input state_e s);
    state_e r;
    case (s)
      S_SIG:       r = S_IHDR_LEN;
      S_IHDR_LEN:  r = S_IHDR_TYPE;
      S_IHDR_TYPE: r = S_IHDR_W;
      S_IHDR_W:    r = S_IHDR_H;
      S_IHDR_H:    r = S_IHDR_TAIL;
      S_IHDR_TAIL: r = S_IHDR_CRC;
      S_IHDR_CRC:  r = S_WAIT_LEN;
      S_IDAT_LEN:  r = S_IDAT_TYPE;
      S_IDAT_TYPE: r = S_ZHDR;
      S_ZHDR:      r = S_RAW;
      S_BLK:       r = S_RAW;
      S_ADLER:     r = S_IDAT_CRC;
      S_IDAT_CRC:  r = S_IEND_LEN;
      S_IEND_LEN:  r = S_IEND_TYPE;
      S_IEND_TYPE: r = S_IEND_CRC;
      default:     r = S_IDLE;
    endcase
    return r;
  endfunction

  function automatic sel_e sel_of(input state_e s);
    sel_e r;
    case (s)
      S_SIG:       r = SEL_SIG;
      S_IHDR_LEN:  r = SEL_LEN13;
      S_IHDR_TYPE: r = SEL_TYPE_IHDR;
      S_IHDR_W:    r = SEL_WIDTH;
      S_IHDR_H:    r = SEL_HEIGHT;
      S_IHDR_TAIL: r = SEL_IHDR_TAIL;
      S_IDAT_LEN:  r = SEL_IDAT_LEN;
      S_IDAT_TYPE: r = SEL_TYPE_IDAT;
      S_ZHDR:      r = SEL_ZHDR;
      S_BLK:       r = SEL_BLK;
      S_ADLER:     r = SEL_ADLER;
      S_IEND_LEN:  r = SEL_ZERO;
      S_IEND_TYPE: r = SEL_TYPE_IEND;
      default:     r = SEL_CRC;
    endcase
    return r;
  endfunction

  assign last = last_idx(state_q);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    filt_d  = filt_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          filt_d  = stat_i.col_zero;
          state_d = phase_q ? S_RAW : S_SIG;
        end
      end
      S_WAIT_LEN: begin
        if (stat_i.calc_done) state_d = S_IDAT_LEN;
      end
      S_RAW: begin
        if (stat_i.blk_zero) begin
          state_d = S_BLK;
        end else if (stat_i.out_free) begin
          if (filt_q) filt_d = 1'b0;
          else state_d = stat_i.raw_last ? S_ADLER : S_IDLE;
        end
      end
      default: begin
        if (stat_i.out_free) begin
          if (idx_q == last) begin
            idx_d   = '0;
            state_d = succ(state_q);
            if (state_q == S_ZHDR)     phase_d = 1'b1;
            if (state_q == S_IEND_CRC) phase_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
    endcase
    if (cfg_restart_i) phase_d = 1'b0;
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_of(state_q);
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch      = in_valid_i;
        cmd_o.calc_start = in_valid_i && !phase_q;
      end
      S_WAIT_LEN: begin
        cmd_o.file_init = stat_i.calc_done;
      end
      S_RAW: begin
        if (!stat_i.blk_zero) begin
          cmd_o.emit     = stat_i.out_free;
          cmd_o.crc_on   = 1'b1;
          cmd_o.raw_step = stat_i.out_free;
          cmd_o.sel      = filt_q ? SEL_FILTER : SEL_SAMPLE;
          cmd_o.col_step = stat_i.out_free && !filt_q;
          cmd_o.run_end  = !filt_q && !stat_i.raw_last;
        end
      end
      default: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.crc_on = (state_q == S_IHDR_TYPE) || (state_q == S_IHDR_W) ||
                       (state_q == S_IHDR_H) || (state_q == S_IHDR_TAIL) ||
                       (state_q == S_IDAT_TYPE) || (state_q == S_ZHDR) ||
                       (state_q == S_BLK) || (state_q == S_ADLER) ||
                       (state_q == S_IEND_TYPE);
        cmd_o.crc_init = (idx_q == '0) && ((state_q == S_IHDR_TYPE) ||
                         (state_q == S_IDAT_TYPE) || (state_q == S_IEND_TYPE));
        cmd_o.blk_load = (state_q == S_BLK) && (idx_q == last) && stat_i.out_free;
        if (state_q == S_IEND_CRC && idx_q == last) begin
          cmd_o.run_end  = 1'b1;
          cmd_o.file_end = 1'b1;
          cmd_o.restart  = stat_i.out_free;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      filt_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      filt_q  <= filt_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pse_chk.sv =====
// ----------------------------------------------------------------------------
// pse_chk
// Port-level checks of the PNG encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_chk import pse_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_end_o,
  input wire logic       file_end_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled output beat changed");

  // the final file byte also closes its run
  a_file_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_end_o |-> run_end_o)
    else $error("file end without run end");

  // one sample at a time: ready drops after an accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

endmodule

bind png_stored_rgb_encoder pse_chk u_pse_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_byte_o (out_byte_o),
  .run_end_o  (run_end_o),
  .file_end_o (file_end_o)
);

`default_nettype wire
